@@ rtl/lbr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line bilinear resampler package
// Shared constants and types for the resampler and its pixel memory.
// ----------------------------------------------------------------------------
package lbr_pkg;
  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int MaxSlices = 4;
  localparam int FracBits  = 8;
  localparam int DirBits   = 14;
  localparam int WBits     = 16;
  localparam int QBits     = FracBits + DirBits;
  localparam int XBits     = $clog2(MaxWidth);
  localparam int YBits     = $clog2(MaxHeight);
  localparam int SBits     = $clog2(MaxSlices);
  localparam int HalfX     = MaxWidth / 2;
  localparam int HalfY     = MaxHeight / 2;
  localparam int BankAw    = SBits + (YBits - 1) + (XBits - 1);
  localparam logic [9:0] DefaultCut = 10'd160;

  typedef enum logic [1:0] {
    CfgOutWidth    = 2'd0,
    CfgImageWidth  = 2'd1,
    CfgImageHeight = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              we;
    logic [SBits-1:0]  ws;
    logic [XBits-1:0]  wx;
    logic [YBits-1:0]  wy;
    logic [7:0]        wd;
    logic              re;
    logic [SBits-1:0]  rs;
    logic [XBits-1:0]  x0;
    logic [XBits-1:0]  x1;
    logic [YBits-1:0]  y0;
    logic [YBits-1:0]  y1;
  } mem_req_t;
endpackage

@@ rtl/lbr_pixel_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel memory
// Four banks split by column and row parity, so the four neighbours of a
// point are read in the same cycle. Read data is registered.
// ----------------------------------------------------------------------------
module lbr_pixel_mem (
  input  logic            clk_i,
  input  lbr_pkg::mem_req_t req_i,
  output logic [7:0]      p00_o,
  output logic [7:0]      p01_o,
  output logic [7:0]      p10_o,
  output logic [7:0]      p11_o
);
  import lbr_pkg::*;

  logic [7:0] bank_q [4][2**BankAw];
  logic [7:0] rd_q [4];
  logic [BankAw-1:0] ra [4];
  logic [1:0] sel_q [4];
  logic [BankAw-1:0] wa;
  logic [1:0] wb;

  // Bank b = {row parity, column parity}.
  assign wb = {req_i.wy[0], req_i.wx[0]};
  assign wa = {req_i.ws, req_i.wy[YBits-1:1], req_i.wx[XBits-1:1]};

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [XBits-1:0] cx;
      logic [YBits-1:0] cy;
      cx = (req_i.x0[0] == b[0]) ? req_i.x0 : req_i.x1;
      cy = (req_i.y0[0] == b[1]) ? req_i.y0 : req_i.y1;
      ra[b] = {req_i.rs, cy[YBits-1:1], cx[XBits-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 4; b++) begin
      if (req_i.we && wb == b[1:0]) begin
        bank_q[b][wa] <= req_i.wd;
      end
      if (req_i.re) begin
        rd_q[b] <= bank_q[b][ra[b]];
      end
    end
  end

  // Remember which bank feeds each neighbour.
  logic [1:0] sel_d [4];
  always_comb begin
    sel_d[0] = {req_i.y0[0], req_i.x0[0]};
    sel_d[1] = {req_i.y1[0], req_i.x0[0]};
    sel_d[2] = {req_i.y0[0], req_i.x1[0]};
    sel_d[3] = {req_i.y1[0], req_i.x1[0]};
  end
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      for (int i = 0; i < 4; i++) sel_q[i] <= sel_d[i];
    end
  end

  assign p00_o = rd_q[sel_q[0]];
  assign p01_o = rd_q[sel_q[1]];
  assign p10_o = rd_q[sel_q[2]];
  assign p11_o = rd_q[sel_q[3]];
endmodule

@@ rtl/line_bilinear_resampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line bilinear resampler
// Samples an image stack along a cut line with bilinear interpolation.
// ----------------------------------------------------------------------------
// Stage 1 to 4 and output registers lie between an accepted word and its result.
// Throughput: one word per cycle unless the output is stalled; the four-bank
// pixel memory reads all four neighbours in the same cycle. A pixel write
// gives no word. Reset clears the pipeline valids and loads the configuration
// registers with their defaults; the pixel memory is undefined until written.
module line_bilinear_resampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [1:0]  slice_i,
  input  logic [7:0]  pix_x_i,
  input  logic [7:0]  pix_y_i,
  input  logic [7:0]  pix_value_i,
  input  logic [15:0] center_x_i,
  input  logic [15:0] center_y_i,
  input  logic signed [15:0] cos_dir_i,
  input  logic signed [15:0] sin_dir_i,
  input  logic [9:0]  pos_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  sample_value_o,
  output logic        outside_o
);
  import lbr_pkg::*;

  logic [9:0] out_width_q;
  logic [8:0] image_width_q, image_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q    <= DefaultCut;
      image_width_q  <= 9'd256;
      image_height_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgOutWidth:    out_width_q <= cfg_data_i;
        CfgImageWidth:  image_width_q <= cfg_data_i[8:0];
        CfgImageHeight: image_height_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances together unless the output is full and stalled.
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, ov_q;
  assign adv = !(ov_q && out_stall_i);
  assign in_stall_o = !adv;
  logic acc_in;
  assign acc_in = in_valid_i && adv;

  // Stage 1: offset d and products.
  logic [9:0] cutw;
  logic [8:0] rr;
  logic signed [10:0] dd;
  assign cutw = (out_width_q == 10'd0) ? DefaultCut : out_width_q;
  assign rr = 9'((cutw - 10'd1) >> 1);
  assign dd = $signed({1'b0, pos_index_i}) - $signed({2'b00, rr});

  logic signed [26:0] mx_q, my_q;
  logic [15:0] cx_q, cy_q;
  logic [SBits:0] s1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx_q <= 27'(cos_dir_i * dd);
      my_q <= 27'(sin_dir_i * dd);
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      s1_q <= {1'b0, slice_i};
    end
  end

  // Stage 2: point in Q22, range check, neighbour addresses.
  logic signed [35:0] px, py;
  assign px = $signed({6'd0, cx_q, 14'd0}) + 36'(mx_q <<< FracBits);
  assign py = $signed({6'd0, cy_q, 14'd0}) + 36'(my_q <<< FracBits);
  logic [8:0] w, h;
  assign w = (image_width_q > 9'(MaxWidth)) ? 9'(MaxWidth) : image_width_q;
  assign h = (image_height_q > 9'(MaxHeight)) ? 9'(MaxHeight) : image_height_q;
  logic outs;
  assign outs = (w == 9'd0) || (h == 9'd0) || px < 0 || py < 0
    || px > $signed({5'd0, w - 9'd1, 22'd0})
    || py > $signed({5'd0, h - 9'd1, 22'd0});
  logic [8:0] x0, y0, x1, y1;
  assign x0 = px[30:22];
  assign y0 = py[30:22];
  assign x1 = (x0 + 9'd1 < w) ? x0 + 9'd1 : w - 9'd1;
  assign y1 = (y0 + 9'd1 < h) ? y0 + 9'd1 : h - 9'd1;

  mem_req_t req;
  always_comb begin
    req.we = acc_in && !operation_i;
    req.ws = slice_i;
    req.wx = pix_x_i;
    req.wy = pix_y_i;
    req.wd = pix_value_i;
    req.re = adv;
    req.rs = s1_q[SBits-1:0];
    req.x0 = x0[XBits-1:0];
    req.x1 = x1[XBits-1:0];
    req.y0 = y0[YBits-1:0];
    req.y1 = y1[YBits-1:0];
  end

  logic [7:0] p00, p01, p10, p11;
  lbr_pixel_mem u_mem (
    .clk_i (clk_i),
    .req_i (req),
    .p00_o (p00),
    .p01_o (p01),
    .p10_o (p10),
    .p11_o (p11)
  );

  logic [15:0] fx_q, fy_q;
  logic out2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx_q <= px[21:6];
      fy_q <= py[21:6];
      out2_q <= outs;
    end
  end

  // Stage 3: horizontal blends.
  logic [16:0] gx, gy;
  assign gx = 17'h10000 - {1'b0, fx_q};
  assign gy = 17'h10000 - {1'b0, fy_q};
  logic [24:0] top_q, bot_q;
  logic [16:0] gy3_q;
  logic [15:0] fy3_q;
  logic out3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      top_q <= 25'(gx * p00) + 25'(fx_q * p10);
      bot_q <= 25'(gx * p01) + 25'(fx_q * p11);
      gy3_q <= gy;
      fy3_q <= fy_q;
      out3_q <= out2_q;
    end
  end

  // Stage 4: vertical blend.
  logic [41:0] acc;
  assign acc = 42'(gy3_q * top_q) + 42'(fy3_q * bot_q);
  logic [7:0] sv_q;
  logic os_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sv_q <= out3_q ? 8'd0 : acc[39:32];
      os_q <= out3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= acc_in && operation_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      ov_q <= v4_q;
    end
  end

  logic [7:0] ovl_q;
  logic oo_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ovl_q <= sv_q;
      oo_q  <= os_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign sample_value_o = ovl_q;
  assign outside_o      = oo_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q)
    else $error("result word lost under stall");
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && oo_q |-> ovl_q == 8'd0)
    else $error("outside word carries a value");
  a_no_take_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ov_q)
    else $error("input stalled with no result waiting");
endmodule

@@ bench/line_bilinear_resampler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line bilinear resampler testbench
// Fills corner regions of every slice, then runs directed sample words and
// random sample and pixel words under several register settings. A scoreboard
// predicts each sample and checks every result word in order. In some phases
// the sender idles between bursts, and the receiver stalls at random.
// ----------------------------------------------------------------------------
module line_bilinear_resampler_tb;
  import lbr_pkg::*;

  localparam int Limit = 600000;
  localparam int OpWrite = 0;
  localparam int OpSample = 1;

  typedef struct {
    bit               op;
    bit [1:0]         slice;
    bit [7:0]         wx;
    bit [7:0]         wy;
    bit [7:0]         wval;
    bit [15:0]        cx;
    bit [15:0]        cy;
    bit signed [15:0] cs;
    bit signed [15:0] sn;
    bit [9:0]         k;
  } word_t;

  typedef struct {
    bit [7:0] value;
    bit       outside;
  } sample_t;

  class lbr_scoreboard;
    bit [7:0] pixel_mem [4][256][256];
    bit       pix_known [4][256][256];
    bit [9:0] cut_width = 10'd160;
    bit [8:0] img_w = 9'd256;
    bit [8:0] img_h = 9'd256;
    sample_t  pending_q[$];
    int       errors, n_checked, n_outside;

    function void set_register(cfg_idx_e idx, bit [9:0] val);
      case (idx)
        CfgOutWidth:    cut_width = val;
        CfgImageWidth:  img_w = val[8:0];
        CfgImageHeight: img_h = val[8:0];
        default: ;
      endcase
    endfunction

    // Works out one sample; known is low if a neighbour was never written.
    function void resample(word_t t, output sample_t res, output bit known);
      longint cs, sn, d, px, py;
      longint one;
      int unsigned cw, r, w, h, x0, y0, x1, y1;
      longint unsigned fx, fy, gx, gy, acc;
      one = 64'd1 << QBits;
      cw = (cut_width == 0) ? int'(DefaultCut) : int'(cut_width);
      r = (cw - 1) / 2;
      d = longint'(t.k) - longint'(r);
      cs = longint'(t.cs);
      sn = longint'(t.sn);
      px = longint'(t.cx) * (64'd1 << DirBits) + cs * d * (64'd1 << FracBits);
      py = longint'(t.cy) * (64'd1 << DirBits) + sn * d * (64'd1 << FracBits);
      w = (img_w > MaxWidth) ? MaxWidth : img_w;
      h = (img_h > MaxHeight) ? MaxHeight : img_h;
      res.value = 0;
      res.outside = 1;
      known = 1;
      if (w == 0 || h == 0 || px < 0 || py < 0 ||
          px > longint'(w - 1) * one || py > longint'(h - 1) * one) return;
      x0 = px >> QBits;
      y0 = py >> QBits;
      fx = (px & (one - 1)) >> (QBits - WBits);
      fy = (py & (one - 1)) >> (QBits - WBits);
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
      known = pix_known[t.slice][y0][x0] && pix_known[t.slice][y1][x0] &&
              pix_known[t.slice][y0][x1] && pix_known[t.slice][y1][x1];
      gx = 65536 - fx;
      gy = 65536 - fy;
      acc = gx * gy * pixel_mem[t.slice][y0][x0] + gx * fy * pixel_mem[t.slice][y1][x0]
          + fx * gy * pixel_mem[t.slice][y0][x1] + fx * fy * pixel_mem[t.slice][y1][x1];
      res.value = acc >> 32;
      res.outside = 0;
    endfunction

    function bit reads_known(word_t t);
      sample_t res;
      bit known;
      resample(t, res, known);
      return known;
    endfunction

    function void note_word(word_t t);
      sample_t res;
      bit known;
      if (t.op == OpWrite) begin
        pixel_mem[t.slice][t.wy][t.wx] = t.wval;
        pix_known[t.slice][t.wy][t.wx] = 1;
      end else begin
        resample(t, res, known);
        pending_q.push_back(res);
      end
    endfunction

    function void check_word(bit [7:0] value, bit outside);
      sample_t want;
      if (pending_q.size() == 0) begin
        $error("result word with no sample pending: value %0d outside %0d", value, outside);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      n_checked++;
      if (outside) n_outside++;
      if (value !== want.value) begin
        $error("sample_value mismatch: expected %0d, actual %0d", want.value, value);
        errors++;
      end
      if (outside !== want.outside) begin
        $error("outside mismatch: expected %0d, actual %0d", want.outside, outside);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_index_i = '0;
  logic [9:0]  cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic        operation_i = 0;
  logic [1:0]  slice_i = '0;
  logic [7:0]  pix_x_i = '0;
  logic [7:0]  pix_y_i = '0;
  logic [7:0]  pix_value_i = '0;
  logic [15:0] center_x_i = '0;
  logic [15:0] center_y_i = '0;
  logic signed [15:0] cos_dir_i = '0;
  logic signed [15:0] sin_dir_i = '0;
  logic [9:0]  pos_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [7:0]  sample_value_o;
  logic        outside_o;

  lbr_scoreboard sb = new();
  int  cycles;
  int  stall_pct;
  bit  bursty;
  int  burst_left;
  int  n_phases;

  line_bilinear_resampler i_dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: checks each accepted result word, then picks its next stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_word(sample_value_o, outside_o);
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic drive_word(word_t t);
    in_valid_i  <= 1;
    operation_i <= t.op;
    slice_i     <= t.slice;
    pix_x_i     <= t.wx;
    pix_y_i     <= t.wy;
    pix_value_i <= t.wval;
    center_x_i  <= t.cx;
    center_y_i  <= t.cy;
    cos_dir_i   <= t.cs;
    sin_dir_i   <= t.sn;
    pos_index_i <= t.k;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(t);
    if (bursty) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid_i <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 20);
      end
    end
  endtask

  // Holds the sender off until every pending sample has come back.
  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_config(bit [9:0] ow, bit [9:0] iw, bit [9:0] ih);
    cfg_we_i    <= 1;
    cfg_index_i <= CfgOutWidth;
    cfg_data_i  <= ow;
    @(posedge clk_i);
    sb.set_register(CfgOutWidth, ow);
    cfg_index_i <= CfgImageWidth;
    cfg_data_i  <= iw;
    @(posedge clk_i);
    sb.set_register(CfgImageWidth, iw);
    cfg_index_i <= CfgImageHeight;
    cfg_data_i  <= ih;
    @(posedge clk_i);
    sb.set_register(CfgImageHeight, ih);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic word_t pixel_word(int s, int x, int y, int v);
    word_t t;
    t = '{default: 0};
    t.op = OpWrite;
    t.slice = s;
    t.wx = x;
    t.wy = y;
    t.wval = v;
    t.cx = $urandom;
    t.k = $urandom;
    return t;
  endfunction

  function automatic word_t sample_word(int s, int cx, int cy, int cs, int sn, int k);
    word_t t;
    t.op = OpSample;
    t.slice = s;
    t.wx = $urandom;
    t.wy = $urandom;
    t.wval = $urandom;
    t.cx = cx;
    t.cy = cy;
    t.cs = cs;
    t.sn = sn;
    t.k = k;
    return t;
  endfunction

  // Random sample, biased towards the written corners and the line centre.
  // Falls back to the origin if no candidate reads only written pixels.
  function automatic word_t random_sample();
    word_t t;
    int cx, cy, r;
    for (int n = 0; n < 30; n++) begin
      case ($urandom_range(0, 2))
        0: begin
          cx = $urandom_range(0, 1023);
          cy = $urandom_range(0, 1023);
        end
        1: begin
          cx = $urandom_range(64512, 65535);
          cy = $urandom_range(64512, 65535);
        end
        default: begin
          cx = $urandom_range(0, 65535);
          cy = $urandom_range(0, 65535);
        end
      endcase
      r = ((sb.cut_width == 0 ? 160 : sb.cut_width) - 1) / 2;
      t = sample_word($urandom_range(0, 3), cx, cy,
                      int'($urandom_range(0, 32768)) - 16384,
                      int'($urandom_range(0, 32768)) - 16384,
                      ($urandom_range(0, 3) != 0) ?
                        (r + int'($urandom_range(0, 16)) - 8) & 1023 :
                        $urandom_range(0, 1022));
      if (t.k > 1022) t.k = 1022;
      if (sb.reads_known(t)) return t;
    end
    return sample_word($urandom_range(0, 3), 0, 0, 0, 0, $urandom_range(0, 1022));
  endfunction

  task automatic random_phase(int count);
    word_t t;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 2) == 0)
          t = pixel_word($urandom_range(0, 3), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255));
        else
          t = pixel_word($urandom_range(0, 3), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom_range(0, 255));
      end else begin
        t = random_sample();
      end
      drive_word(t);
    end
  endtask

  task automatic run_phase(bit [9:0] ow, bit [9:0] iw, bit [9:0] ih, int count);
    drain();
    set_config(ow, iw, ih);
    stall_pct = (n_phases % 4) * 25;
    bursty = n_phases[0];
    burst_left = $urandom_range(1, 20);
    n_phases++;
    random_phase(count);
  endtask

  initial begin
    word_t directed[$];
    stall_pct = 0;
    bursty = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Both corner blocks of every slice are written so that samples there
    // read only known pixels.
    for (int s = 0; s < 4; s++)
      for (int y = 0; y < 4; y++)
        for (int x = 0; x < 4; x++) begin
          drive_word(pixel_word(s, x, y, $urandom_range(0, 255)));
          drive_word(pixel_word(s, 252 + x, 252 + y, $urandom_range(0, 255)));
        end
    drive_word(pixel_word(3, 255, 255, 255));
    drive_word(pixel_word(0, 0, 0, 0));

    // Directed samples under the reset settings.
    stall_pct = 40;
    directed.push_back(sample_word(0, 0, 0, 0, 0, 0));
    directed.push_back(sample_word(3, 65535, 65535, 0, 0, 1022));
    directed.push_back(sample_word(1, 384, 384, 16384, 0, 79));
    directed.push_back(sample_word(1, 384, 384, 16384, 0, 80));
    directed.push_back(sample_word(2, 384, 384, -16384, -16384, 84));
    directed.push_back(sample_word(2, 384, 384, 0, 16384, 76));
    directed.push_back(sample_word(0, 0, 0, -16384, 0, 80));
    directed.push_back(sample_word(0, 0, 0, 0, -16384, 80));
    directed.push_back(sample_word(0, 0, 0, 16384, 16384, 1022));
    directed.push_back(sample_word(3, 65280, 65280, 0, 0, 5));
    directed.push_back(sample_word(1, 500, 300, 11585, 11585, 80));
    directed.push_back(sample_word(2, 64800, 64600, -11585, 11585, 80));
    directed.push_back(sample_word(0, 700, 500, 9000, -13000, 79));
    foreach (directed[i])
      if (sb.reads_known(directed[i])) drive_word(directed[i]);

    run_phase(10'd160, 10'd256, 10'd256, 40);
    run_phase(10'd0, 10'd16, 10'd16, 40);
    run_phase(10'd1, 10'd2, 10'd2, 30);
    run_phase(10'd1023, 10'd256, 10'd256, 40);
    run_phase(10'd5, 10'd511, 10'd511, 40);
    run_phase(10'd77, 10'd0, 10'd40, 20);
    run_phase(10'd160, 10'd40, 10'd0, 20);
    run_phase(10'd33, 10'd16, 10'd256, 40);
    drain();

    $display("Covered %0d phases of register settings; %0d sample results checked, %0d outside.",
             n_phases + 1, sb.n_checked, sb.n_outside);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
